/* sv/tea_pkg.sv */
// Shared types, constants and round functions for the TEA block cipher.
// No dependencies.
`default_nettype none

package tea_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned ROUND_COUNT_DEF = 16;
  localparam int unsigned CFG_INDEX_W     = 4;
  localparam logic [WORD_W-1:0] DELTA     = 32'h9e37_79b9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_A = 4'd0,
    REG_KEY_B = 4'd1,
    REG_KEY_C = 4'd2,
    REG_KEY_D = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } key_t;

  // delta * k mod 2^32, used at elaboration only
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned k);
    logic [63:0] prod;
    prod = 64'(DELTA) * 64'(k);
    return prod[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] mix_half(input logic [WORD_W-1:0] h,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] ka,
                                                 input logic [WORD_W-1:0] kb);
    return ((h << 4) + ka) ^ (h + sum) ^ ((h >> 5) + kb);
  endfunction

endpackage

`default_nettype wire

/* sv/tea_key_regs.sv */
// Key register file written through the configuration channel.
// Depends on tea_pkg.
`default_nettype none

module tea_key_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tea_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tea_pkg::WORD_W-1:0]       cfg_data,
  output tea_pkg::key_t                         key
);

  tea_pkg::key_t key_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    key_next = key;
    if (cfg_valid) begin
      case (cfg_index)
        tea_pkg::REG_KEY_A: key_next.a = cfg_data;
        tea_pkg::REG_KEY_B: key_next.b = cfg_data;
        tea_pkg::REG_KEY_C: key_next.c = cfg_data;
        tea_pkg::REG_KEY_D: key_next.d = cfg_data;
        default:            key_next   = key;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else begin
      key <= key_next;
    end
  end

endmodule

`default_nettype wire

/* sv/tea_half_stage.sv */
// One pipeline stage: a single TEA half-round, encrypt or decrypt per item.
// Depends on tea_pkg.
`default_nettype none

module tea_half_stage #(
  parameter int unsigned ROUND_COUNT = tea_pkg::ROUND_COUNT_DEF,
  parameter int unsigned IDX         = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tea_pkg::key_t               key,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_mode,
  input  wire logic [tea_pkg::WORD_W-1:0]  in_y,
  input  wire logic [tea_pkg::WORD_W-1:0]  in_z,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_mode,
  output logic [tea_pkg::WORD_W-1:0]       out_y,
  output logic [tea_pkg::WORD_W-1:0]       out_z
);

  localparam int unsigned ROUND = IDX / 2;
  localparam logic        ODD   = 1'((IDX % 2) == 1);
  localparam logic [tea_pkg::WORD_W-1:0] ENC_SUM = tea_pkg::round_sum(ROUND + 1);
  localparam logic [tea_pkg::WORD_W-1:0] DEC_SUM = tea_pkg::round_sum(ROUND_COUNT - ROUND);

  logic                       upd_y;
  logic [tea_pkg::WORD_W-1:0] src, dst, ka, kb, sum, mix, res;
  logic [tea_pkg::WORD_W-1:0] y_next, z_next;

  // encrypt: even half updates y, odd updates z; decrypt the reverse
  always_comb begin
    upd_y  = in_mode ^ ~ODD;
    src    = upd_y ? in_z  : in_y;
    dst    = upd_y ? in_y  : in_z;
    ka     = upd_y ? key.a : key.c;
    kb     = upd_y ? key.b : key.d;
    sum    = in_mode ? DEC_SUM : ENC_SUM;
    mix    = tea_pkg::mix_half(src, sum, ka, kb);
    res    = in_mode ? (dst - mix) : (dst + mix);
    y_next = upd_y ? res  : in_y;
    z_next = upd_y ? in_z : res;
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_mode <= in_mode;
      out_y    <= y_next;
      out_z    <= z_next;
    end
  end

endmodule

`default_nettype wire

/* sv/tea_block_cipher.sv */
// Top level of the pipelined TEA block cipher, one half-round per stage.
// Depends on tea_pkg, tea_key_regs and tea_half_stage.
//
//  channel  direction  signals                    payload
//  s_axis   in         tvalid tready tdata tuser  tdata: first, second half; tuser: mode
//  m_axis   out        tvalid tready tdata        tdata: first, second half
//  cfg      in         valid ready index data     key word write, index 0..3
//
// One register stage per half-round.
// One item enters per cycle while s_axis_tready is high; each stage holds its item while the next cannot take it.
// Synchronous reset empties the pipeline and clears the key words.
// A stall at m_axis backs up stage by stage; empty stages still take items.
`default_nettype none

module tea_block_cipher #(
  parameter int unsigned ROUND_COUNT = tea_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [2*tea_pkg::WORD_W-1:0]     s_axis_tdata,  // first_half_in, second_half_in
  input  wire logic                             s_axis_tuser,  // mode
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [2*tea_pkg::WORD_W-1:0]          m_axis_tdata,  // first_half_out, second_half_out
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tea_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tea_pkg::WORD_W-1:0]       cfg_data
);

  localparam int unsigned STAGES = 2 * ROUND_COUNT;

  tea_pkg::key_t key;

  logic                       vld [STAGES+1];
  logic                       rdy [STAGES+1];
  logic                       mde [STAGES+1];
  logic [tea_pkg::WORD_W-1:0] y   [STAGES+1];
  logic [tea_pkg::WORD_W-1:0] z   [STAGES+1];

  tea_key_regs u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign vld[0]        = s_axis_tvalid;
  assign mde[0]        = s_axis_tuser;
  assign y[0]          = s_axis_tdata[tea_pkg::WORD_W-1:0];
  assign z[0]          = s_axis_tdata[2*tea_pkg::WORD_W-1:tea_pkg::WORD_W];
  assign s_axis_tready = rdy[0];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    tea_half_stage #(
      .ROUND_COUNT (ROUND_COUNT),
      .IDX         (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_mode   (mde[i]),
      .in_y      (y[i]),
      .in_z      (z[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_mode  (mde[i+1]),
      .out_y     (y[i+1]),
      .out_z     (z[i+1])
    );
  end

  assign rdy[STAGES]   = m_axis_tready;
  assign m_axis_tvalid = vld[STAGES];
  assign m_axis_tdata  = {z[STAGES], y[STAGES]};

endmodule

`default_nettype wire

/* sv/tea_checker.sv */
// Port-level checks for the TEA block cipher, bound to the top level.
// Depends on tea_pkg and tea_block_cipher.
`default_nettype none

module tea_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [2*tea_pkg::WORD_W-1:0]     m_axis_tdata,
  input wire logic                             cfg_ready
);

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("item out right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output item changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config channel not ready");

endmodule

bind tea_block_cipher tea_checker u_tea_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);

`default_nettype wire

/* dv/tea_block_cipher_tb.sv */
// Self-checking testbench for tea_block_cipher: TEA encrypt and decrypt items are
// predicted by a local 16-round model and compared with every output block.
// Depends on tea_pkg and tea_block_cipher.
`default_nettype none

module tea_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned PIPE_DEPTH = 2 * tea_pkg::ROUND_COUNT_DEF;
  localparam int unsigned IDX_W = tea_pkg::CFG_INDEX_W;
  localparam int unsigned WORD_W = tea_pkg::WORD_W;
  localparam logic [IDX_W-1:0] TOP_INDEX = '1;
  localparam logic [IDX_W-1:0] FIRST_UNUSED_INDEX = IDX_W'(tea_pkg::REG_KEY_D + 1);
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  typedef enum logic {
    ENCRYPT = 1'b0,
    DECRYPT = 1'b1
  } cipher_mode_t;

  // first half in the low bits, as on tdata
  typedef struct packed {
    logic [WORD_W-1:0] second;
    logic [WORD_W-1:0] first;
  } tea_block_t;

  typedef struct packed {
    cipher_mode_t op;
    tea_block_t   data;
  } block_item_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [2*WORD_W-1:0]      s_axis_tdata = '0;   // first_half_in, second_half_in
  logic                     s_axis_tuser = 1'b0; // mode
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [2*WORD_W-1:0]      m_axis_tdata;        // first_half_out, second_half_out
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [WORD_W-1:0]        cfg_data = '0;

  block_item_t    pending[$];
  tea_block_t     predicted_blocks[$];
  tea_pkg::key_t  key_words = '0;
  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;
  int unsigned    src_idle_pct = 22;
  int unsigned    sink_idle_pct = 22;
  int unsigned    hold_requests = 0;
  int unsigned    hold_served = 0;
  int unsigned    hold_left = 0;

  tea_block_cipher dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic tea_block_t tea_cipher(cipher_mode_t op, tea_block_t blk,
                                            tea_pkg::key_t k);
    logic [WORD_W-1:0] y, z, s;
    int                i;
    tea_block_t        r;
    y = blk.first;
    z = blk.second;
    if (op == ENCRYPT) begin
      s = '0;
      for (i = 0; i < tea_pkg::ROUND_COUNT_DEF; i++) begin
        s = s + tea_pkg::DELTA;
        y = y + (((z << 4) + k.a) ^ (z + s) ^ ((z >> 5) + k.b));
        z = z + (((y << 4) + k.c) ^ (y + s) ^ ((y >> 5) + k.d));
      end
    end else begin
      s = tea_pkg::DELTA * tea_pkg::ROUND_COUNT_DEF;
      for (i = 0; i < tea_pkg::ROUND_COUNT_DEF; i++) begin
        z = z - (((y << 4) + k.c) ^ (y + s) ^ ((y >> 5) + k.d));
        y = y - (((z << 4) + k.a) ^ (z + s) ^ ((z >> 5) + k.b));
        s = s - tea_pkg::DELTA;
      end
    end
    r.first = y;
    r.second = z;
    return r;
  endfunction

  // mostly random, sometimes an extreme
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tea_block_cipher_tb: FAIL");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    block_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= nxt.data;
        s_axis_tuser <= nxt.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= SINK_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // monitor: key tracking, prediction and output check
  always @(posedge clk) begin
    tea_block_t got, want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tea_pkg::REG_KEY_A: key_words.a = cfg_data;
          tea_pkg::REG_KEY_B: key_words.b = cfg_data;
          tea_pkg::REG_KEY_C: key_words.c = cfg_data;
          tea_pkg::REG_KEY_D: key_words.d = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_blocks.push_back(tea_cipher(cipher_mode_t'(s_axis_tuser),
                                              s_axis_tdata, key_words));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (predicted_blocks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected block: expected none, got %h", $time, got);
        end else begin
          want = predicted_blocks.pop_front();
          if (got.first !== want.first) begin
            mismatches++;
            $display("%0t: first_half_out: expected %h, got %h", $time, want.first, got.first);
          end
          if (got.second !== want.second) begin
            mismatches++;
            $display("%0t: second_half_out: expected %h, got %h", $time, want.second,
                     got.second);
          end
        end
      end
    end
  end

  task automatic write_key(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_block(input cipher_mode_t op, input logic [WORD_W-1:0] first,
                             input logic [WORD_W-1:0] second);
    block_item_t it;
    it.op = op;
    it.data.first = first;
    it.data.second = second;
    pending.push_back(it);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || s_axis_tvalid || predicted_blocks.size() != 0);
  endtask

  initial begin
    tea_block_t  plain, ct;
    int unsigned p, n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // keys at reset value
    queue_block(ENCRYPT, '0, '0);
    queue_block(DECRYPT, '0, '0);
    queue_block(ENCRYPT, ALL_ONES, ALL_ONES);
    queue_block(DECRYPT, ALL_ONES, ALL_ONES);
    queue_block(ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
    queue_block(DECRYPT, 32'h8000_0000, 32'h0000_0001);
    drain();

    // all-ones key; unknown indexes must leave it alone
    write_key(tea_pkg::REG_KEY_A, ALL_ONES);
    write_key(tea_pkg::REG_KEY_B, ALL_ONES);
    write_key(tea_pkg::REG_KEY_C, ALL_ONES);
    write_key(tea_pkg::REG_KEY_D, ALL_ONES);
    write_key(FIRST_UNUSED_INDEX, '0);
    write_key(TOP_INDEX, $urandom);
    queue_block(ENCRYPT, '0, ALL_ONES);
    queue_block(DECRYPT, ALL_ONES, '0);
    queue_block(ENCRYPT, 32'h0000_0001, 32'h8000_0000);
    queue_block(DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
    drain();

    // random key, round trips both ways
    write_key(tea_pkg::REG_KEY_A, $urandom);
    write_key(tea_pkg::REG_KEY_B, $urandom);
    write_key(tea_pkg::REG_KEY_C, $urandom);
    write_key(tea_pkg::REG_KEY_D, $urandom);
    for (n = 0; n < 3; n++) begin
      plain.first = $urandom;
      plain.second = $urandom;
      ct = tea_cipher(ENCRYPT, plain, key_words);
      queue_block(ENCRYPT, plain.first, plain.second);
      queue_block(DECRYPT, ct.first, ct.second);
      ct = tea_cipher(DECRYPT, plain, key_words);
      queue_block(ENCRYPT, ct.first, ct.second);
    end
    drain();

    for (p = 0; p < 6; p++) begin
      if (p == 0) begin
        write_key(tea_pkg::REG_KEY_A, '0);
        write_key(tea_pkg::REG_KEY_B, '0);
        write_key(tea_pkg::REG_KEY_C, '0);
        write_key(tea_pkg::REG_KEY_D, '0);
      end else begin
        write_key(tea_pkg::REG_KEY_C, pick_word());
        write_key(tea_pkg::REG_KEY_A, pick_word());
        write_key(tea_pkg::REG_KEY_D, pick_word());
        write_key(tea_pkg::REG_KEY_B, pick_word());
      end
      if ($urandom_range(2) == 0)
        write_key(IDX_W'($urandom_range(TOP_INDEX, FIRST_UNUSED_INDEX)), $urandom);
      src_idle_pct = (p <= 1) ? 0 : 22;
      sink_idle_pct = (p == 0) ? 0 : 22;
      if (p == 1)
        hold_requests++;   // receiver stalls while the sender keeps offering
      for (n = 0; n < 67; n++)
        queue_block(cipher_mode_t'($urandom_range(1)), pick_word(), pick_word());
      drain();
    end

    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && predicted_blocks.size() == 0) begin
      $display("tea_block_cipher_tb: PASS");
    end else begin
      $display("tea_block_cipher_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/tea_pkg.sv
sv/tea_key_regs.sv
sv/tea_half_stage.sv
sv/tea_block_cipher.sv
sv/tea_checker.sv
dv/tea_block_cipher_tb.sv
